// File: sv/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg: shared definitions for the queue and reserve stack block
// Field widths, action and status codes, default sizes and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package frs_pkg;

    // Port field widths.
    localparam int ACTION_W = 2;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // Default sizes.
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int TAG_BITS_DEF    = 16;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_ADD     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PLAY    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RECOVER = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QFULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QEMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SFULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SEMPTY = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                capture;
        logic                commit;
        logic                q_push;
        logic                q_pop;
        logic                s_push;
        logic                s_pop;
        logic                push_from_stack;
        logic [STATUS_W-1:0] status;
    } frs_cmd_t;

    // Occupancy flags from the datapath to the controller.
    typedef struct packed {
        logic q_empty;
        logic q_full;
        logic s_empty;
        logic s_full;
    } frs_stat_t;

endpackage

// File: sv/frs_ctrl.sv
// ----------------------------------------------------------------------------
// frs_ctrl: action sequencer
// Takes one input word at a time, checks the occupancy flags and issues the
// queue and stack moves, then hands the result word to the output register.
// ----------------------------------------------------------------------------
module frs_ctrl
    import frs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACTION_W-1:0] action,
    output logic                out_valid,
    input  logic                out_stall,
    input  frs_stat_t           stat,
    output frs_cmd_t            cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [ACTION_W-1:0] action_reg;
    logic                capture;
    logic                commit;

    // Input side is open only between actions.
    assign in_stall  = (state_reg != S_IDLE);
    assign capture   = in_valid && (state_reg == S_IDLE);
    assign commit    = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    // Decide the outcome of the held action from the occupancy flags.
    always_comb
    begin
        cmd                 = '0;
        cmd.capture         = capture;
        cmd.commit          = commit;
        cmd.status          = ST_OK;
        unique case (action_reg)
            ACT_ADD:
            begin
                if (stat.q_full)
                begin
                    cmd.status = ST_QFULL;
                end
                else
                begin
                    cmd.q_push = 1'b1;
                end
            end
            ACT_PLAY:
            begin
                if (stat.q_empty)
                begin
                    cmd.status = ST_QEMPTY;
                end
                else
                begin
                    cmd.q_pop = 1'b1;
                end
            end
            ACT_RESERVE:
            begin
                priority if (stat.q_empty)
                begin
                    cmd.status = ST_QEMPTY;
                end
                else if (stat.s_full)
                begin
                    cmd.status = ST_SFULL;
                end
                else
                begin
                    cmd.q_pop  = 1'b1;
                    cmd.s_push = 1'b1;
                end
            end
            ACT_RECOVER:
            begin
                priority if (stat.s_empty)
                begin
                    cmd.status = ST_SEMPTY;
                end
                else if (stat.q_full)
                begin
                    cmd.status = ST_QFULL;
                end
                else
                begin
                    cmd.s_pop           = 1'b1;
                    cmd.q_push          = 1'b1;
                    cmd.push_from_stack = 1'b1;
                end
            end
            default:
            begin
                cmd.status = ST_OK;
            end
        endcase
    end

    // Next state and output valid.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Held action word.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            action_reg <= action;
        end
    end

`ifndef SYNTHESIS
    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("result loaded while output word still stalled");

    // A rejected action moves nothing.
    a_reject_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.status != ST_OK) |-> !(cmd.q_push || cmd.q_pop || cmd.s_push || cmd.s_pop))
        else $error("rejected action still moves a tag");

    // Each finished action yields a valid result word on the next cycle.
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished action did not present a result");
`endif

endmodule

// File: sv/frs_dpath.sv
// ----------------------------------------------------------------------------
// frs_dpath: queue and stack storage
// Holds the queue and stack memories, pointers, occupancy counts and the
// output result register; carries out the moves the controller commands.
// ----------------------------------------------------------------------------
module frs_dpath
    import frs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [TAG_W-1:0]    item_tag,
    input  frs_cmd_t            cmd,
    output frs_stat_t           stat,
    output logic [STATUS_W-1:0] status,
    output logic [TAG_W-1:0]    moved_tag,
    output logic [COUNT_W-1:0]  queue_count,
    output logic [COUNT_W-1:0]  stack_count
);

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QF_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int SF_W = $clog2(STACK_DEPTH + 1);

    logic [TAG_BITS-1:0] qmem [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] smem [STACK_DEPTH];

    logic [QA_W-1:0]     head_ptr_reg;
    logic [QA_W-1:0]     head_ptr_next;
    logic [QA_W-1:0]     tail_ptr_reg;
    logic [QA_W-1:0]     tail_ptr_next;
    logic [QF_W-1:0]     queue_fill_reg;
    logic [QF_W-1:0]     queue_fill_next;
    logic [SF_W-1:0]     stack_fill_reg;
    logic [SF_W-1:0]     stack_fill_next;
    logic [SF_W-1:0]     stack_top;

    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] q_rd_reg;
    logic [TAG_BITS-1:0] s_rd_reg;
    logic [TAG_BITS-1:0] push_data;
    logic [TAG_BITS-1:0] moved_next;
    logic [63:0]         tag_wide;
    logic [63:0]         moved_wide;
    logic [31:0]         qfill_wide;
    logic [31:0]         sfill_wide;

    logic [STATUS_W-1:0] status_reg;
    logic [TAG_BITS-1:0] moved_reg;
    logic [COUNT_W-1:0]  queue_count_reg;
    logic [COUNT_W-1:0]  stack_count_reg;

    logic do_qpush;
    logic do_qpop;
    logic do_spush;
    logic do_spop;

    // Occupancy flags.
    assign stat.q_empty = (queue_fill_reg == '0);
    assign stat.q_full  = (queue_fill_reg == QF_W'(QUEUE_DEPTH));
    assign stat.s_empty = (stack_fill_reg == '0);
    assign stat.s_full  = (stack_fill_reg == SF_W'(STACK_DEPTH));

    assign do_qpush = cmd.commit && cmd.q_push;
    assign do_qpop  = cmd.commit && cmd.q_pop;
    assign do_spush = cmd.commit && cmd.s_push;
    assign do_spop  = cmd.commit && cmd.s_pop;

    assign stack_top = stack_fill_reg - SF_W'(1);
    assign tag_wide  = 64'(item_tag);

    // Tag that enters the queue, and the tag reported in the result.
    always_comb
    begin
        push_data = cmd.push_from_stack ? s_rd_reg : tag_reg;
        priority if (cmd.q_push)
        begin
            moved_next = push_data;
        end
        else if (cmd.q_pop)
        begin
            moved_next = q_rd_reg;
        end
        else
        begin
            moved_next = '0;
        end
    end

    // Pointer and occupancy updates.
    always_comb
    begin
        head_ptr_next   = head_ptr_reg;
        tail_ptr_next   = tail_ptr_reg;
        queue_fill_next = queue_fill_reg;
        stack_fill_next = stack_fill_reg;
        if (do_qpush)
        begin
            tail_ptr_next   = (tail_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : tail_ptr_reg + 1'b1;
            queue_fill_next = queue_fill_reg + 1'b1;
        end
        if (do_qpop)
        begin
            head_ptr_next   = (head_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : head_ptr_reg + 1'b1;
            queue_fill_next = queue_fill_reg - 1'b1;
        end
        if (do_spush)
        begin
            stack_fill_next = stack_fill_reg + 1'b1;
        end
        if (do_spop)
        begin
            stack_fill_next = stack_top;
        end
    end

    assign qfill_wide = 32'(queue_fill_next);
    assign sfill_wide = 32'(stack_fill_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg   <= '0;
            tail_ptr_reg   <= '0;
            queue_fill_reg <= '0;
            stack_fill_reg <= '0;
        end
        else
        begin
            head_ptr_reg   <= head_ptr_next;
            tail_ptr_reg   <= tail_ptr_next;
            queue_fill_reg <= queue_fill_next;
            stack_fill_reg <= stack_fill_next;
        end
    end

    // Queue memory: read the head on capture, write the tail on commit.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            q_rd_reg <= qmem[head_ptr_reg];
        end
        if (do_qpush)
        begin
            qmem[tail_ptr_reg] <= push_data;
        end
    end

    // Stack memory: read the top on capture, write above it on commit.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            s_rd_reg <= smem[stack_top[SA_W-1:0]];
        end
        if (do_spush)
        begin
            smem[stack_fill_reg[SA_W-1:0]] <= q_rd_reg;
        end
    end

    // Held input tag and the result register.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tag_reg <= tag_wide[TAG_BITS-1:0];
        end
        if (cmd.commit)
        begin
            status_reg      <= cmd.status;
            moved_reg       <= moved_next;
            queue_count_reg <= qfill_wide[COUNT_W-1:0];
            stack_count_reg <= sfill_wide[COUNT_W-1:0];
        end
    end

    assign moved_wide  = 64'(moved_reg);
    assign status      = status_reg;
    assign moved_tag   = moved_wide[TAG_W-1:0];
    assign queue_count = queue_count_reg;
    assign stack_count = stack_count_reg;

`ifndef SYNTHESIS
    // The queue count never passes its depth.
    a_qfill_range: assert property (@(posedge clk) disable iff (!rst_n)
        queue_fill_reg <= QF_W'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

    // The stack count never passes its depth.
    a_sfill_range: assert property (@(posedge clk) disable iff (!rst_n)
        stack_fill_reg <= SF_W'(STACK_DEPTH))
        else $error("stack occupancy out of range");

    // Pointers only move when an action finishes.
    a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> ($stable(head_ptr_reg) && $stable(tail_ptr_reg)
                         && $stable(stack_fill_reg)))
        else $error("pointer moved without a finished action");
`endif

endmodule

// File: sv/fifo_with_reserve_stack_unit.sv
// ----------------------------------------------------------------------------
// fifo_with_reserve_stack_unit: circular tag queue with a reserve stack
// Top level joining the action sequencer and the storage datapath.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall) carries one word per action:
//   action selects add, play, reserve or recover, and item_tag is the tag
//   that add appends. The output channel (out_valid, out_stall) returns one
//   word per action with the status, the tag moved and both occupancy counts
//   after the action. Rejected actions report their status and a zero tag.
//   On the accepting edge an action reads the queue head and the stack top
//   from their synchronous memories; the edge that finishes it writes the
//   memory that takes a tag and loads the result register, and out_valid
//   rises at that same edge. The block takes no new word until the previous
//   action has finished.
//   A new word is accepted while the previous result still waits. If the
//   receiver stalls, the finished action holds in the sequencer until the
//   output register frees, and in_stall stays high in the meantime.
//   Reset empties the queue and stack at once; memory contents are left as
//   they are, and no unwritten entry ever reaches a result.
// ----------------------------------------------------------------------------
module fifo_with_reserve_stack_unit
    import frs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [TAG_W-1:0]    item_tag,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [TAG_W-1:0]    moved_tag,
    output logic [COUNT_W-1:0]  queue_count,
    output logic [COUNT_W-1:0]  stack_count
);

    frs_cmd_t  cmd;
    frs_stat_t stat;

    // Action sequencer.
    frs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Queue, stack and result register.
    frs_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STACK_DEPTH (STACK_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_tag    (item_tag),
        .cmd         (cmd),
        .stat        (stat),
        .status      (status),
        .moved_tag   (moved_tag),
        .queue_count (queue_count),
        .stack_count (stack_count)
    );

endmodule

// File: tb/fifo_with_reserve_stack_unit_tb.sv
// ----------------------------------------------------------------------------
// fifo_with_reserve_stack_unit_tb: self-checking bench for the tag queue
// A short table of directed actions runs first. Random actions follow,
// steered toward chosen queue and stack fill levels so that the empty and
// full corners and their rejection codes are reached. Each accepted word is
// run through a local predictor. Every result word is compared field by field
// with the oldest prediction. Both channels idle in random bursts, except in
// the closing stretch.
// ----------------------------------------------------------------------------
module fifo_with_reserve_stack_unit_tb;

    import frs_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 12;
    localparam int QDEPTH          = QUEUE_DEPTH_DEF;
    localparam int SDEPTH          = STACK_DEPTH_DEF;
    localparam int RANDOM_WORDS    = 1330;
    localparam int QUIET_WORDS     = 150;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_CYCLES = 250_000;
    localparam int DIRECTED_ROWS   = 25;

    // Tags are kept in TAG_BITS bits.
    localparam logic [TAG_W-1:0] TAG_KEEP =
        (TAG_BITS_DEF >= TAG_W) ? '1 : TAG_W'((1 << TAG_BITS_DEF) - 1);

    // One result word as the block reports it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    moved;
        logic [COUNT_W-1:0]  queue_count;
        logic [COUNT_W-1:0]  stack_count;
    } action_report_t;

    // One row of the directed table; the report is used only when pinned.
    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [TAG_W-1:0]    tag;
        logic                pinned;
        action_report_t      report;
    } directed_row_t;

    // Directed actions: empty-structure rejections after reset, extreme tags,
    // every action, LIFO order on the stack and a recover on an empty stack.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ACT_PLAY,    16'h1234, 1'b1, '{ST_QEMPTY, 16'h0000, 7'd0, 7'd0}},
        '{ACT_RESERVE, 16'hFFFF, 1'b1, '{ST_QEMPTY, 16'h0000, 7'd0, 7'd0}},
        '{ACT_RECOVER, 16'h0001, 1'b1, '{ST_SEMPTY, 16'h0000, 7'd0, 7'd0}},
        '{ACT_ADD,     16'hFFFF, 1'b1, '{ST_OK,     16'hFFFF, 7'd1, 7'd0}},
        '{ACT_ADD,     16'h0000, 1'b1, '{ST_OK,     16'h0000, 7'd2, 7'd0}},
        '{ACT_RESERVE, 16'h0000, 1'b1, '{ST_OK,     16'hFFFF, 7'd1, 7'd1}},
        '{ACT_RECOVER, 16'hFFFF, 1'b0, '0},
        '{ACT_PLAY,    16'hFFFF, 1'b0, '0},
        '{ACT_PLAY,    16'h0000, 1'b0, '0},
        '{ACT_PLAY,    16'hC3C3, 1'b0, '0},
        '{ACT_ADD,     16'hA5A5, 1'b0, '0},
        '{ACT_ADD,     16'h5A5A, 1'b0, '0},
        '{ACT_ADD,     16'h8001, 1'b0, '0},
        '{ACT_RESERVE, 16'h0F0F, 1'b0, '0},
        '{ACT_RESERVE, 16'hF0F0, 1'b0, '0},
        '{ACT_RECOVER, 16'h0000, 1'b0, '0},
        '{ACT_RECOVER, 16'hFFFF, 1'b0, '0},
        '{ACT_RECOVER, 16'h7777, 1'b1, '{ST_SEMPTY, 16'h0000, 7'd3, 7'd0}},
        '{ACT_PLAY,    16'h0000, 1'b0, '0},
        '{ACT_PLAY,    16'h0000, 1'b0, '0},
        '{ACT_PLAY,    16'h0000, 1'b0, '0},
        '{ACT_ADD,     16'h7FFE, 1'b0, '0},
        '{ACT_RESERVE, 16'h0000, 1'b0, '0},
        '{ACT_RESERVE, 16'hFFFF, 1'b1, '{ST_QEMPTY, 16'h0000, 7'd0, 7'd1}},
        '{ACT_RECOVER, 16'h0000, 1'b0, '0}
    };

    // Block ports.
    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action      = ACT_ADD;
    logic [TAG_W-1:0]    item_tag    = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    moved_tag;
    logic [COUNT_W-1:0]  queue_count;
    logic [COUNT_W-1:0]  stack_count;

    // Predictor state: the queue ring and the reserve stack.
    logic [TAG_W-1:0] shadow_queue [QDEPTH];
    logic [TAG_W-1:0] shadow_stack [SDEPTH];
    int               shadow_head  = 0;
    int               shadow_tail  = 0;
    int               shadow_qfill = 0;
    int               shadow_sfill = 0;

    // Predicted reports waiting for their result word, oldest first.
    action_report_t expected_reports [$];

    int error_count     = 0;
    int results_checked = 0;
    int random_sent     = 0;
    int goals_reached   = 0;
    int status_tally [5] = '{default: 0};
    int send_gap_pct    = 0;
    int recv_stall_pct  = 0;

    fifo_with_reserve_stack_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .item_tag    (item_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .moved_tag   (moved_tag),
        .queue_count (queue_count),
        .stack_count (stack_count)
    );

    // Free-running clock.
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Append a tag at the queue tail, wrapping the pointer.
    function automatic void queue_append(input logic [TAG_W-1:0] tag);
        shadow_queue[shadow_tail] = tag;
        shadow_tail = (shadow_tail == QDEPTH - 1) ? 0 : shadow_tail + 1;
        shadow_qfill++;
    endfunction

    // Remove the queue head, wrapping the pointer.
    function automatic logic [TAG_W-1:0] queue_take();
        logic [TAG_W-1:0] tag;
        tag = shadow_queue[shadow_head];
        shadow_head = (shadow_head == QDEPTH - 1) ? 0 : shadow_head + 1;
        shadow_qfill--;
        return tag;
    endfunction

    // Apply one action to the predictor state and return the report it gives.
    function automatic action_report_t apply_action(input logic [ACTION_W-1:0] act,
                                                    input logic [TAG_W-1:0]    tag);
        action_report_t rep;
        rep.status = ST_OK;
        rep.moved  = '0;
        case (act)
            ACT_ADD:
            begin
                if (shadow_qfill >= QDEPTH)
                    rep.status = ST_QFULL;
                else
                begin
                    queue_append(tag & TAG_KEEP);
                    rep.moved = tag & TAG_KEEP;
                end
            end
            ACT_PLAY:
            begin
                if (shadow_qfill == 0)
                    rep.status = ST_QEMPTY;
                else
                    rep.moved = queue_take();
            end
            ACT_RESERVE:
            begin
                // Queue empty takes priority over stack full.
                if (shadow_qfill == 0)
                    rep.status = ST_QEMPTY;
                else if (shadow_sfill >= SDEPTH)
                    rep.status = ST_SFULL;
                else
                begin
                    rep.moved = queue_take();
                    shadow_stack[shadow_sfill] = rep.moved;
                    shadow_sfill++;
                end
            end
            ACT_RECOVER:
            begin
                // Stack empty takes priority over queue full.
                if (shadow_sfill == 0)
                    rep.status = ST_SEMPTY;
                else if (shadow_qfill >= QDEPTH)
                    rep.status = ST_QFULL;
                else
                begin
                    shadow_sfill--;
                    rep.moved = shadow_stack[shadow_sfill];
                    queue_append(rep.moved);
                end
            end
        endcase
        rep.queue_count = COUNT_W'(shadow_qfill);
        rep.stack_count = COUNT_W'(shadow_sfill);
        return rep;
    endfunction

    // Choose the action that moves the fill levels toward a target.
    function automatic logic [ACTION_W-1:0] step_toward(input int goal_q, input int goal_s);
        if (shadow_sfill < goal_s)
            return (shadow_qfill > 0) ? ACT_RESERVE : ACT_ADD;
        if (shadow_sfill > goal_s)
            return (shadow_qfill < QDEPTH) ? ACT_RECOVER : ACT_PLAY;
        if (shadow_qfill < goal_q)
            return ACT_ADD;
        return ACT_PLAY;
    endfunction

    // Target fill level, biased toward empty and full.
    function automatic int pick_level(input int depth);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 0;
        if (r < 8)
            return depth;
        return $urandom_range(0, depth);
    endfunction

    // Idle rate for one stretch of the run, sometimes none at all.
    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 4;
            2:       return 12;
            default: return 30;
        endcase
    endfunction

    function automatic void compare_field(input string field,
                                          input logic [TAG_W-1:0] want,
                                          input logic [TAG_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            error_count++;
        end
    endfunction

    // Offer one word, wait for its acceptance, then record its prediction.
    task automatic send_word(input logic [ACTION_W-1:0] act,
                             input logic [TAG_W-1:0]    tag,
                             input logic                pinned,
                             input action_report_t      pinned_rep);
        action_report_t rep;
        if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        item_tag <= tag;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        rep = apply_action(act, tag);
        if (pinned)
            rep = pinned_rep;
        expected_reports.push_back(rep);
        status_tally[rep.status]++;
    endtask

    // One random-phase word; the closing stretch runs without idling.
    task automatic send_random(input logic [ACTION_W-1:0] act);
        if (random_sent >= RANDOM_WORDS - QUIET_WORDS)
        begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
        end
        send_word(act, TAG_W'($urandom_range(0, 16'hFFFF)), 1'b0, '0);
        random_sent++;
    endtask

    // Stimulus: reset, directed table, then goal-steered random actions.
    initial
    begin : stimulus
        int goal_idx;
        int goal_q;
        int goal_s;
        int extra;
        goal_idx = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_gap_pct   = 10;
        recv_stall_pct = 10;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_word(DIRECTED[i].act, DIRECTED[i].tag, DIRECTED[i].pinned,
                      DIRECTED[i].report);

        // The first four targets are the corners; the rest are drawn.
        while (random_sent < RANDOM_WORDS)
        begin
            if (goal_idx < 4)
            begin
                goal_q = (goal_idx < 2) ? QDEPTH : 0;
                goal_s = (goal_idx == 1 || goal_idx == 2) ? SDEPTH : 0;
            end
            else
            begin
                goal_q = pick_level(QDEPTH);
                goal_s = pick_level(SDEPTH);
            end
            goal_idx++;
            send_gap_pct   = pick_pct();
            recv_stall_pct = pick_pct();

            // Mostly steered actions with some noise mixed in.
            while ((shadow_qfill != goal_q || shadow_sfill != goal_s)
                   && random_sent < RANDOM_WORDS)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_random(ACTION_W'($urandom_range(0, 3)));
                else
                    send_random(step_toward(goal_q, goal_s));
            end
            if (shadow_qfill == goal_q && shadow_sfill == goal_s)
                goals_reached++;

            // A few random actions at the target, where rejections show up.
            extra = $urandom_range(2, 6);
            repeat (extra)
            begin
                if (random_sent < RANDOM_WORDS)
                    send_random(ACTION_W'($urandom_range(0, 3)));
            end
        end
        in_valid <= 1'b0;

        while (expected_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d words (%0d directed), %0d results checked, %0d fill targets hit.",
                 DIRECTED_ROWS + random_sent, DIRECTED_ROWS, results_checked, goals_reached);
        $display("Status mix: %0d ok, %0d queue full, %0d queue empty, %0d stack full, %0d stack empty.",
                 status_tally[ST_OK], status_tally[ST_QFULL], status_tally[ST_QEMPTY],
                 status_tally[ST_SFULL], status_tally[ST_SEMPTY]);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Receiver back-pressure in random bursts.
    initial
    begin : receiver_stall
        forever
        begin
            @(posedge clk);
            if (rst_n && recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Result check. Sampling at the falling edge sees the values that the
    // next rising edge accepts, after all predictions of earlier edges.
    always @(negedge clk)
    begin : report_check
        action_report_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("result word with nothing expected: status %0d, tag %0d",
                       status, moved_tag);
                error_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                compare_field("status", TAG_W'(want.status), TAG_W'(status));
                compare_field("moved_tag", want.moved, moved_tag);
                compare_field("queue_count", TAG_W'(want.queue_count), TAG_W'(queue_count));
                compare_field("stack_count", TAG_W'(want.stack_count), TAG_W'(stack_count));
                results_checked++;
            end
        end
    end

    // Watchdog against a hung handshake.
    initial
    begin : watchdog
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $error("run timed out with %0d results outstanding", expected_reports.size());
        $display("FAIL");
        $finish;
    end

endmodule
